FILE: src/stcws_pkg.sv
// Package for the square tone channel: beat types, event codes and register numbers.
package stcws_pkg;

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] reg_index;
      logic [7:0] reg_value;
   } req_type;

   typedef struct packed {
      logic [3:0] sample;
      logic       channel_on;
   } rsp_type;

   typedef struct packed {
      logic        overflow;
      logic [10:0] next_freq;
   } sweep_res_type;

   localparam logic [2:0] MODE_WRITE    = 3'd0;
   localparam logic [2:0] MODE_TIMER    = 3'd1;
   localparam logic [2:0] MODE_LENGTH   = 3'd2;
   localparam logic [2:0] MODE_ENVELOPE = 3'd3;
   localparam logic [2:0] MODE_SWEEP    = 3'd4;

   localparam logic [2:0] REG_SWEEP    = 3'd0;
   localparam logic [2:0] REG_LENGTH   = 3'd1;
   localparam logic [2:0] REG_ENVELOPE = 3'd2;
   localparam logic [2:0] REG_FREQ_LO  = 3'd3;
   localparam logic [2:0] REG_FREQ_HI  = 3'd4;

   localparam int unsigned NUM_REGS = 5;

   localparam logic [31:0] DUTY_TABLE_RESET = 32'h7E87_8101;
   localparam logic [13:0] FREQ_TIMER_RESET = 14'd8192;
   localparam logic [7:0]  DEFAULT_PERIOD   = 8'd8;
   localparam logic [6:0]  LENGTH_FULL      = 7'd64;
   localparam logic [11:0] FREQ_SPAN        = 12'd2048;
   localparam logic [3:0]  VOLUME_MAX       = 4'd15;

endpackage

FILE: src/square_tone_channel_with_sweep.sv
// Square tone channel with volume envelope, length counter and frequency sweep.

// Each request beat carries one event (register write, timer step, length tick,
// envelope tick or sweep tick) and produces exactly one response beat with the
// channel's level after that event. The event is applied in the cycle it is
// accepted and the response is registered, so the response is valid in the next cycle and a new
// beat is taken every cycle while the response side keeps up; req_ready only falls
// while a response is held back by rsp_ready. The duty table register may be
// written at any time the channel has no response outstanding.
module square_tone_channel_with_sweep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  stcws_pkg::req_type    req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output stcws_pkg::rsp_type    rsp_data,
   input  logic                  csr_write_enable,
   input  logic [31:0]           csr_write_data
);
   import stcws_pkg::*;

   logic [31:0] duty_table_ff;
   logic [7:0]  regs_ff [NUM_REGS];
   logic [7:0]  regs_in [NUM_REGS];
   logic [13:0] freq_timer_ff, freq_timer_in;
   logic [2:0]  duty_pos_ff, duty_pos_in;
   logic [1:0]  duty_sel_ff, duty_sel_in;
   logic [3:0]  volume_ff, volume_in;
   logic [7:0]  env_count_ff, env_count_in;
   logic        env_running_ff, env_running_in;
   logic [6:0]  length_ff, length_in;
   logic        length_gate_ff, length_gate_in;
   logic [7:0]  sweep_count_ff, sweep_count_in;
   logic        sweep_running_ff, sweep_running_in;
   logic        sweep_down_ff, sweep_down_in;
   logic [10:0] shadow_ff, shadow_in;
   logic        enabled_ff, enabled_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        accept;

   function automatic sweep_res_type sweep_calc(input logic [10:0] shadow,
                                                input logic [7:0]  ctrl);
      logic [11:0]   delta;
      logic [11:0]   sum;
      sweep_res_type res;
      delta = {1'b0, shadow >> ctrl[2:0]};
      sum   = ctrl[3] ? ({1'b0, shadow} - delta) : ({1'b0, shadow} + delta);
      res.overflow  = sum[11];
      res.next_freq = sum[10:0];
      return res;
   endfunction

   function automatic logic [13:0] reload_of(input logic [10:0] freq);
      logic [11:0] span;
      span = FREQ_SPAN - {1'b0, freq};
      return {span, 2'b00};
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      logic [10:0]   cur_freq;
      logic [10:0]   trig_freq;
      logic [13:0]   trig_reload;
      logic [2:0]    env_period;
      logic [2:0]    sw_period;
      logic [2:0]    sw_shift;
      logic [13:0]   timer_dec;
      logic [7:0]    count_dec;
      sweep_res_type first;
      sweep_res_type second;
      logic          on;
      logic          duty_bit;

      for (int i = 0; i < NUM_REGS; i++) begin
         regs_in[i] = regs_ff[i];
      end
      freq_timer_in    = freq_timer_ff;
      duty_pos_in      = duty_pos_ff;
      duty_sel_in      = duty_sel_ff;
      volume_in        = volume_ff;
      env_count_in     = env_count_ff;
      env_running_in   = env_running_ff;
      length_in        = length_ff;
      length_gate_in   = length_gate_ff;
      sweep_count_in   = sweep_count_ff;
      sweep_running_in = sweep_running_ff;
      sweep_down_in    = sweep_down_ff;
      shadow_in        = shadow_ff;
      enabled_in       = enabled_ff;

      cur_freq    = {regs_ff[4][2:0], regs_ff[3]};
      trig_freq   = {req_data.reg_value[2:0], regs_ff[3]};
      trig_reload = reload_of(trig_freq);
      env_period  = regs_ff[2][2:0];
      sw_period   = regs_ff[0][6:4];
      sw_shift    = regs_ff[0][2:0];
      timer_dec   = freq_timer_ff - 14'd1;
      count_dec   = 8'd0;
      first       = sweep_calc(shadow_ff, regs_ff[0]);
      second      = '0;

      unique case (req_data.mode)
         MODE_WRITE: begin
            unique case (req_data.reg_index)
               REG_SWEEP: begin
                  regs_in[0] = req_data.reg_value;
                  if (sweep_running_ff && sweep_down_ff && !req_data.reg_value[3]) begin
                     enabled_in = 1'b0;
                  end
               end
               REG_LENGTH: begin
                  regs_in[1]  = req_data.reg_value;
                  length_in   = {1'b0, req_data.reg_value[5:0]};
                  duty_sel_in = req_data.reg_value[7:6];
               end
               REG_ENVELOPE: regs_in[2] = req_data.reg_value;
               REG_FREQ_LO:  regs_in[3] = req_data.reg_value;
               REG_FREQ_HI: begin
                  regs_in[4] = req_data.reg_value;
                  if (req_data.reg_value[7]) begin
                     // Trigger: reload every unit from the freshly written registers.
                     env_count_in   = (env_period != 3'd0) ? {5'd0, env_period}
                                                           : DEFAULT_PERIOD;
                     env_running_in = 1'b1;
                     volume_in      = regs_ff[2][7:4];
                     if (length_ff == 7'd0) begin
                        length_in = LENGTH_FULL;
                     end
                     freq_timer_in    = {trig_reload[13:2], freq_timer_ff[1:0]};
                     duty_pos_in      = 3'd0;
                     shadow_in        = trig_freq;
                     sweep_count_in   = (sw_period != 3'd0) ? {5'd0, sw_period}
                                                            : DEFAULT_PERIOD;
                     sweep_running_in = (sw_period != 3'd0) && (sw_shift != 3'd0);
                     sweep_down_in    = 1'b0;
                     enabled_in       = 1'b1;
                     if (sw_shift != 3'd0) begin
                        second        = sweep_calc(trig_freq, regs_ff[0]);
                        sweep_down_in = regs_ff[0][3];
                        if (second.overflow) begin
                           enabled_in = 1'b0;
                        end
                     end
                  end
                  length_gate_in = req_data.reg_value[6];
               end
               default: ;
            endcase
         end
         MODE_TIMER: begin
            freq_timer_in = timer_dec;
            if (timer_dec == 14'd0) begin
               freq_timer_in = reload_of(cur_freq);
               duty_pos_in   = duty_pos_ff + 3'd1;
            end
         end
         MODE_LENGTH: begin
            if (length_gate_ff && length_ff != 7'd0) begin
               length_in = length_ff - 7'd1;
            end
         end
         MODE_ENVELOPE: begin
            if (env_running_ff) begin
               count_dec    = env_count_ff - 8'd1;
               env_count_in = count_dec;
               if (count_dec == 8'd0) begin
                  env_count_in = (env_period != 3'd0) ? {5'd0, env_period}
                                                      : DEFAULT_PERIOD;
                  if (env_period != 3'd0) begin
                     if (regs_ff[2][3] && volume_ff != VOLUME_MAX) begin
                        volume_in = volume_ff + 4'd1;
                     end else if (!regs_ff[2][3] && volume_ff != 4'd0) begin
                        volume_in = volume_ff - 4'd1;
                     end else begin
                        env_running_in = 1'b0;
                     end
                  end
               end
            end
         end
         MODE_SWEEP: begin
            count_dec      = sweep_count_ff - 8'd1;
            sweep_count_in = count_dec;
            if (count_dec == 8'd0) begin
               sweep_count_in = (sw_period != 3'd0) ? {5'd0, sw_period} : DEFAULT_PERIOD;
               if (sweep_running_ff && sw_period != 3'd0) begin
                  // Commit the new frequency, then check the one after it for overflow.
                  sweep_down_in = regs_ff[0][3];
                  if (first.overflow) begin
                     enabled_in = 1'b0;
                  end else if (sw_shift != 3'd0) begin
                     shadow_in  = first.next_freq;
                     regs_in[3] = first.next_freq[7:0];
                     regs_in[4] = {regs_ff[4][7:3], first.next_freq[10:8]};
                  end
                  second = sweep_calc(shadow_in, regs_ff[0]);
                  if (second.overflow) begin
                     enabled_in = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase

      on       = enabled_in && (!length_gate_in || length_in != 7'd0);
      duty_bit = duty_table_ff[{duty_sel_in, duty_pos_in}];
      rsp_data_in.channel_on = on;
      rsp_data_in.sample     = (on && duty_bit) ? volume_in : 4'd0;

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_table_ff    <= DUTY_TABLE_RESET;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= 8'd0;
         end
         freq_timer_ff    <= FREQ_TIMER_RESET;
         duty_pos_ff      <= 3'd0;
         duty_sel_ff      <= 2'd0;
         volume_ff        <= 4'd0;
         env_count_ff     <= 8'd0;
         env_running_ff   <= 1'b0;
         length_ff        <= 7'd0;
         length_gate_ff   <= 1'b0;
         sweep_count_ff   <= 8'd0;
         sweep_running_ff <= 1'b0;
         sweep_down_ff    <= 1'b0;
         shadow_ff        <= 11'd0;
         enabled_ff       <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            duty_table_ff <= csr_write_data;
         end
         if (accept) begin
            for (int i = 0; i < NUM_REGS; i++) begin
               regs_ff[i] <= regs_in[i];
            end
            freq_timer_ff    <= freq_timer_in;
            duty_pos_ff      <= duty_pos_in;
            duty_sel_ff      <= duty_sel_in;
            volume_ff        <= volume_in;
            env_count_ff     <= env_count_in;
            env_running_ff   <= env_running_in;
            length_ff        <= length_in;
            length_gate_ff   <= length_gate_in;
            sweep_count_ff   <= sweep_count_in;
            sweep_running_ff <= sweep_running_in;
            sweep_down_ff    <= sweep_down_in;
            shadow_ff        <= shadow_in;
            enabled_ff       <= enabled_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the square tone channel, with its own level predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import stcws_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 100000;
   localparam int unsigned PHASE_EVENTS = 135;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_write_enable;
   logic [31:0] csr_write_data;

   req_type     pending_events[$];
   rsp_type     expected_levels[$];
   bit          req_taken;
   int unsigned gap_pct;
   int unsigned stall_pct;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   // Predicted channel state.
   logic [31:0] duty_table;
   logic [7:0]  chan_regs[NUM_REGS];
   logic [13:0] freq_timer;
   logic [2:0]  duty_pos;
   logic [1:0]  duty_sel;
   logic [3:0]  volume;
   logic [7:0]  env_count;
   bit          env_running;
   logic [6:0]  length_count;
   bit          length_gate;
   logic [7:0]  sweep_count;
   bit          sweep_running;
   bit          sweep_down;
   logic [10:0] shadow_freq;
   bit          chan_enabled;

   square_tone_channel_with_sweep i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [10:0] tone_freq();
      return {chan_regs[REG_FREQ_HI][2:0], chan_regs[REG_FREQ_LO]};
   endfunction

   function automatic logic [13:0] timer_reload();
      logic [13:0] span;
      span = 14'(FREQ_SPAN - {1'b0, tone_freq()});
      return span << 2;
   endfunction

   function automatic void sweep_update(input bit commit);
      logic [2:0]  shift;
      logic [11:0] delta;
      logic [11:0] next_freq;
      shift      = chan_regs[REG_SWEEP][2:0];
      sweep_down = chan_regs[REG_SWEEP][3];
      delta      = {1'b0, shadow_freq} >> shift;
      next_freq  = sweep_down ? {1'b0, shadow_freq} - delta : {1'b0, shadow_freq} + delta;
      if (next_freq >= FREQ_SPAN) begin
         chan_enabled = 1'b0;
      end else if (shift != 0 && commit) begin
         shadow_freq = next_freq[10:0];
         chan_regs[REG_FREQ_LO] = next_freq[7:0];
         chan_regs[REG_FREQ_HI] = {chan_regs[REG_FREQ_HI][7:3], next_freq[10:8]};
      end
   endfunction

   function automatic void trigger_note();
      logic [2:0]  env_period;
      logic [2:0]  sw_period;
      logic [2:0]  sw_shift;
      logic [13:0] reload;
      env_period  = chan_regs[REG_ENVELOPE][2:0];
      sw_period   = chan_regs[REG_SWEEP][6:4];
      sw_shift    = chan_regs[REG_SWEEP][2:0];
      env_count   = (env_period != 0) ? {5'b0, env_period} : DEFAULT_PERIOD;
      env_running = 1'b1;
      volume      = chan_regs[REG_ENVELOPE][7:4];
      if (length_count == 0) begin
         length_count = LENGTH_FULL;
      end
      // The two low timer bits survive a trigger.
      reload        = timer_reload();
      freq_timer    = {reload[13:2], freq_timer[1:0]};
      duty_pos      = '0;
      shadow_freq   = tone_freq();
      sweep_count   = (sw_period != 0) ? {5'b0, sw_period} : DEFAULT_PERIOD;
      sweep_running = (sw_period != 0) && (sw_shift != 0);
      sweep_down    = 1'b0;
      chan_enabled  = 1'b1;
      if (sw_shift != 0) begin
         sweep_update(1'b0);
      end
   endfunction

   function automatic void apply_write(input logic [2:0] idx, input logic [7:0] value);
      if (idx <= REG_FREQ_HI) begin
         chan_regs[idx] = value;
         case (idx)
            REG_SWEEP: begin
               if (sweep_running && sweep_down && !value[3]) begin
                  chan_enabled = 1'b0;
               end
            end
            REG_LENGTH: begin
               length_count = {1'b0, value[5:0]};
               duty_sel     = value[7:6];
            end
            REG_FREQ_HI: begin
               if (value[7]) begin
                  trigger_note();
               end
               length_gate = value[6];
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void envelope_tick();
      logic [2:0] period;
      bit         up;
      if (env_running) begin
         env_count = env_count - 1'b1;
         if (env_count == 0) begin
            period    = chan_regs[REG_ENVELOPE][2:0];
            up        = chan_regs[REG_ENVELOPE][3];
            env_count = (period != 0) ? {5'b0, period} : DEFAULT_PERIOD;
            if (period != 0) begin
               if (up ? (volume < VOLUME_MAX) : (volume > 0)) begin
                  volume = up ? volume + 1'b1 : volume - 1'b1;
               end else begin
                  env_running = 1'b0;
               end
            end
         end
      end
   endfunction

   function automatic void sweep_tick();
      logic [2:0] period;
      sweep_count = sweep_count - 1'b1;
      if (sweep_count == 0) begin
         period      = chan_regs[REG_SWEEP][6:4];
         sweep_count = (period != 0) ? {5'b0, period} : DEFAULT_PERIOD;
         if (sweep_running && period != 0) begin
            sweep_update(1'b1);
            sweep_update(1'b0);
         end
      end
   endfunction

   function automatic rsp_type predict_level(input req_type beat);
      rsp_type level;
      bit      on;
      case (beat.mode)
         MODE_WRITE: apply_write(beat.reg_index, beat.reg_value);
         MODE_TIMER: begin
            freq_timer = freq_timer - 1'b1;
            if (freq_timer == 0) begin
               freq_timer = timer_reload();
               duty_pos   = duty_pos + 1'b1;
            end
         end
         MODE_LENGTH: begin
            if (length_gate && length_count != 0) begin
               length_count = length_count - 1'b1;
            end
         end
         MODE_ENVELOPE: envelope_tick();
         MODE_SWEEP: sweep_tick();
         default: ;
      endcase
      on = chan_enabled && (!length_gate || length_count != 0);
      level.channel_on = on;
      level.sample     = (on && duty_table[{duty_sel, duty_pos}]) ? volume : 4'd0;
      return level;
   endfunction

   function automatic void reset_channel_model();
      duty_table = DUTY_TABLE_RESET;
      foreach (chan_regs[i]) begin
         chan_regs[i] = '0;
      end
      freq_timer    = FREQ_TIMER_RESET;
      duty_pos      = '0;
      duty_sel      = '0;
      volume        = '0;
      env_count     = '0;
      env_running   = 1'b0;
      length_count  = '0;
      length_gate   = 1'b0;
      sweep_count   = '0;
      sweep_running = 1'b0;
      sweep_down    = 1'b0;
      shadow_freq   = '0;
      chan_enabled  = 1'b1;
   endfunction

   function automatic void push_event(input logic [2:0] mode, input logic [2:0] idx,
                                      input logic [7:0] value);
      req_type beat;
      beat.mode      = mode;
      beat.reg_index = idx;
      beat.reg_value = value;
      pending_events.push_back(beat);
   endfunction

   // Ticks and writes with random payload; a few beats are unknown modes or
   // writes to registers that do not exist.
   function automatic void push_random_event();
      int unsigned pick;
      logic [2:0]  mode;
      logic [2:0]  idx;
      pick = $urandom_range(99);
      idx  = 3'($urandom);
      if (pick < 30) begin
         mode = MODE_TIMER;
      end else if (pick < 40) begin
         mode = MODE_LENGTH;
      end else if (pick < 52) begin
         mode = MODE_ENVELOPE;
      end else if (pick < 64) begin
         mode = MODE_SWEEP;
      end else if (pick < 94) begin
         mode = MODE_WRITE;
         idx  = 3'($urandom_range(4));
      end else if (pick < 97) begin
         mode = 3'($urandom_range(7, 5));
      end else begin
         mode = MODE_WRITE;
         idx  = 3'($urandom_range(7, 5));
      end
      push_event(mode, idx, 8'($urandom));
   endfunction

   // One note: set up all registers, trigger, then a burst of events.
   function automatic int unsigned push_note();
      int unsigned burst;
      logic [7:0]  freq_lo;
      logic [7:0]  freq_hi;
      burst   = $urandom_range(30, 10);
      freq_lo = ($urandom_range(1) != 0) ? 8'($urandom_range(255, 240)) : 8'($urandom);
      freq_hi = 8'($urandom);
      freq_hi[7] = 1'b1;
      if ($urandom_range(9) < 6) begin
         freq_hi[2:0] = 3'd7;
      end
      push_event(MODE_WRITE, REG_SWEEP, 8'($urandom));
      push_event(MODE_WRITE, REG_LENGTH, 8'($urandom));
      push_event(MODE_WRITE, REG_ENVELOPE, 8'($urandom));
      push_event(MODE_WRITE, REG_FREQ_LO, freq_lo);
      push_event(MODE_WRITE, REG_FREQ_HI, freq_hi);
      for (int unsigned i = 0; i < burst; i++) begin
         push_random_event();
      end
      return burst + 5;
   endfunction

   task automatic wait_until_drained();
      while (pending_events.size() != 0 || req_valid || expected_levels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_duty_table(input logic [31:0] value);
      wait_until_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      duty_table = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Beat driver: the payload changes only at the falling edge.
   always @(negedge clock) begin : drive_req
      if (!reset && !(req_valid && !req_taken)) begin
         if (pending_events.size() != 0 && $urandom_range(99) >= gap_pct) begin
            req_data  <= pending_events.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : accept_req
      if (!reset && req_valid && req_ready) begin
         expected_levels.push_back(predict_level(req_data));
         req_taken = 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_levels.size() == 0) begin
            $error("unexpected response beat: sample %0d, channel_on %0d",
                   rsp_data.sample, rsp_data.channel_on);
            mismatch_count++;
         end else begin
            want = expected_levels.pop_front();
            if (rsp_data.sample !== want.sample) begin
               $error("sample: expected %0d, actual %0d", want.sample, rsp_data.sample);
               mismatch_count++;
            end
            if (rsp_data.channel_on !== want.channel_on) begin
               $error("channel_on: expected %0d, actual %0d",
                      want.channel_on, rsp_data.channel_on);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] table_settings[4];
      int unsigned queued;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_taken        = 1'b0;
      gap_pct          = 29;
      stall_pct        = 29;
      mismatch_count   = 0;
      cycle_count      = 0;
      reset_channel_model();

      // Directed: ticks from reset (the sweep countdown wraps), unknown modes,
      // writes to missing registers, sweep overflow at trigger, the envelope
      // stopping at full volume, the subtract-mode disable, length expiry and
      // a trigger that reloads an empty length counter.
      push_event(MODE_SWEEP, 3'd0, 8'h00);
      push_event(MODE_TIMER, 3'd7, 8'hFF);
      push_event(MODE_LENGTH, 3'd0, 8'h00);
      push_event(MODE_ENVELOPE, 3'd7, 8'hFF);
      push_event(3'd5, 3'd7, 8'hFF);
      push_event(3'd6, 3'd0, 8'h00);
      push_event(3'd7, 3'd7, 8'hFF);
      push_event(MODE_WRITE, 3'd7, 8'hFF);
      push_event(MODE_WRITE, 3'd5, 8'h00);
      push_event(MODE_WRITE, REG_SWEEP, 8'h11);
      push_event(MODE_WRITE, REG_LENGTH, 8'hFF);
      push_event(MODE_WRITE, REG_FREQ_LO, 8'hFF);
      push_event(MODE_WRITE, REG_ENVELOPE, 8'hF9);
      push_event(MODE_WRITE, REG_FREQ_HI, 8'hC7);
      push_event(MODE_ENVELOPE, 3'd0, 8'h00);
      push_event(MODE_WRITE, REG_SWEEP, 8'h19);
      push_event(MODE_WRITE, REG_FREQ_HI, 8'h87);
      push_event(MODE_SWEEP, 3'd0, 8'h00);
      push_event(MODE_WRITE, REG_SWEEP, 8'h11);
      push_event(MODE_WRITE, REG_SWEEP, 8'h70);
      push_event(MODE_WRITE, REG_LENGTH, 8'h41);
      push_event(MODE_WRITE, REG_FREQ_HI, 8'hC0);
      push_event(MODE_LENGTH, 3'd0, 8'h00);
      push_event(MODE_WRITE, REG_FREQ_HI, 8'hC0);
      push_event(MODE_TIMER, 3'd0, 8'h00);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      table_settings[0] = 32'h0000_0000;
      table_settings[1] = 32'hFFFF_FFFF;
      table_settings[2] = $urandom;
      table_settings[3] = DUTY_TABLE_RESET;
      for (int p = 0; p < 4; p++) begin
         // Each duty table write waits for the channel to drain first.
         write_duty_table(table_settings[p]);
         gap_pct   = (p == 2) ? 0 : 29;
         stall_pct = gap_pct;
         queued    = 0;
         while (queued < PHASE_EVENTS) begin
            queued += push_note();
         end
      end

      wait_until_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
